FILE: rtl/rca_pkg.sv
`timescale 1ns / 1ps

package rca_pkg;

    localparam int NUM_IDS_DEF    = 256;
    localparam int COUNT_BITS_DEF = 16;

    localparam int CMD_W       = 2;
    localparam int TARGET_W    = 8;
    localparam int RESULT_ID_W = 8;
    localparam int STATUS_W    = 3;
    localparam int USE_COUNT_W = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_RETAIN  = 2'd1,
        CMD_RELEASE = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_EXHAUSTED = 3'd1,
        ST_UNUSED    = 3'd2,
        ST_RANGE     = 3'd3,
        ST_SATURATED = 3'd4
    } status_t;

    // What the issue stage decided for one command
    typedef enum logic [2:0] {
        OP_ALLOC   = 3'd0,
        OP_RETAIN  = 3'd1,
        OP_RELEASE = 3'd2,
        OP_RANGE   = 3'd3,
        OP_EXHAUST = 3'd4
    } op_t;

    typedef struct packed {
        op_t                    op;
        logic [RESULT_ID_W-1:0] res_id;
    } issue_t;

endpackage

FILE: rtl/rca_cnt_ram.sv
`timescale 1ns / 1ps

module rca_cnt_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 16,
    parameter int AW    = 8
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] cnt_mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            cnt_mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= cnt_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/rca_issue.sv
`timescale 1ns / 1ps

module rca_issue #(
    parameter int NUM_IDS = 256,
    parameter int ID_W    = 8,
    parameter int FRESH_W = 9
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_accept,
    input  logic [rca_pkg::CMD_W-1:0]       cmd,
    input  logic [rca_pkg::TARGET_W-1:0]    target_id,
    input  logic                            rel_set,
    input  logic [ID_W-1:0]                 rel_id,
    output rca_pkg::issue_t                 iss,
    output logic [ID_W-1:0]                 iss_id
);

    import rca_pkg::*;

    logic [NUM_IDS-1:0] rec_reg;
    logic [NUM_IDS-1:0] rec_next;
    logic [NUM_IDS-1:0] rec_eff;
    logic [NUM_IDS-1:0] set_vec;
    logic [NUM_IDS-1:0] clr_vec;
    logic [FRESH_W-1:0] fresh_reg;
    logic [FRESH_W-1:0] fresh_next;
    logic [ID_W-1:0]    enc_id;
    logic               found;
    logic               in_range;
    logic               take_fresh;
    logic               take_rec;

    // A release finishing in the execute stage this cycle is visible here
    assign set_vec = rel_set ? (NUM_IDS'(1) << rel_id) : '0;
    assign rec_eff = rec_reg | set_vec;
    assign found   = |rec_eff;

    always_comb
    begin
        enc_id = '0;
        for (int i = NUM_IDS - 1; i >= 0; i--)
        begin
            if (rec_eff[i])
            begin
                enc_id = ID_W'(i);
            end
        end
    end

    assign in_range = 32'(target_id) < 32'(NUM_IDS);

    always_comb
    begin
        iss.op     = OP_RANGE;
        iss.res_id = target_id;
        iss_id     = ID_W'(target_id);
        take_fresh = 1'b0;
        take_rec   = 1'b0;
        case (cmd)
            CMD_ALLOC:
            begin
                if (found)
                begin
                    iss.op   = OP_ALLOC;
                    iss_id   = enc_id;
                    take_rec = 1'b1;
                end
                else if (fresh_reg < FRESH_W'(NUM_IDS))
                begin
                    iss.op     = OP_ALLOC;
                    iss_id     = ID_W'(fresh_reg);
                    take_fresh = 1'b1;
                end
                else
                begin
                    iss.op = OP_EXHAUST;
                    iss_id = '0;
                end
                iss.res_id = RESULT_ID_W'(iss_id);
            end
            CMD_RETAIN:
            begin
                if (in_range)
                begin
                    iss.op = OP_RETAIN;
                end
            end
            CMD_RELEASE:
            begin
                if (in_range)
                begin
                    iss.op = OP_RELEASE;
                end
            end
            default:
            begin
                iss.op = OP_RANGE;
            end
        endcase
    end

    assign clr_vec    = (in_accept && take_rec) ? (NUM_IDS'(1) << enc_id) : '0;
    assign rec_next   = rec_eff & ~clr_vec;
    assign fresh_next = (in_accept && take_fresh) ? fresh_reg + FRESH_W'(1) : fresh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_reg   <= '0;
            fresh_reg <= '0;
        end
        else
        begin
            rec_reg   <= rec_next;
            fresh_reg <= fresh_next;
        end
    end

endmodule

FILE: rtl/rca_exec.sv
`timescale 1ns / 1ps

module rca_exec #(
    parameter int NUM_IDS    = 256,
    parameter int COUNT_BITS = 16,
    parameter int ID_W       = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_accept,
    input  rca_pkg::issue_t                    iss,
    input  logic [ID_W-1:0]                    iss_id,
    input  logic [COUNT_BITS-1:0]              rd_cnt,
    output logic                               s1_load,
    output logic                               rel_set,
    output logic [ID_W-1:0]                    rel_id,
    output logic                               ram_we,
    output logic [ID_W-1:0]                    ram_waddr,
    output logic [COUNT_BITS-1:0]              ram_wdata,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [rca_pkg::RESULT_ID_W-1:0]    result_id,
    output logic [rca_pkg::STATUS_W-1:0]       status,
    output logic [rca_pkg::USE_COUNT_W-1:0]    use_count
);

    import rca_pkg::*;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic                    s1_vld_reg;
    issue_t                  s1_iss_reg;
    logic [ID_W-1:0]         s1_id_reg;

    logic [NUM_IDS-1:0]      cnt_vld_reg;
    logic                    bp_vld_reg;
    logic [ID_W-1:0]         bp_id_reg;
    logic [COUNT_BITS-1:0]   bp_cnt_reg;

    logic                    out_vld_reg;
    logic [RESULT_ID_W-1:0]  res_id_reg;
    status_t                 status_reg;
    logic [USE_COUNT_W-1:0]  use_cnt_reg;

    logic                    s1_adv;
    logic                    s1_fire;
    logic                    bp_hit;
    logic [COUNT_BITS-1:0]   cur_cnt;
    logic [COUNT_BITS-1:0]   new_cnt;
    logic [COUNT_BITS-1:0]   res_cnt;
    status_t                 st;
    logic                    wr;
    logic                    mark;

    assign s1_adv  = !out_vld_reg || !out_stall;
    assign s1_load = !s1_vld_reg || s1_adv;
    assign s1_fire = s1_vld_reg && s1_adv;

    // The RAM read was registered as this command entered s1; a write made at that same edge is in the bypass
    assign bp_hit  = bp_vld_reg && (bp_id_reg == s1_id_reg);
    assign cur_cnt = !cnt_vld_reg[s1_id_reg] ? '0 : (bp_hit ? bp_cnt_reg : rd_cnt);

    always_comb
    begin
        new_cnt = cur_cnt;
        res_cnt = '0;
        st      = ST_OK;
        wr      = 1'b0;
        mark    = 1'b0;
        case (s1_iss_reg.op)
            OP_ALLOC, OP_RETAIN:
            begin
                if (cur_cnt == CNT_MAX)
                begin
                    st = ST_SATURATED;
                end
                else
                begin
                    new_cnt = cur_cnt + COUNT_BITS'(1);
                    wr      = 1'b1;
                end
                res_cnt = new_cnt;
            end
            OP_RELEASE:
            begin
                if (cur_cnt == '0)
                begin
                    st   = ST_UNUSED;
                    mark = 1'b1;
                end
                else
                begin
                    new_cnt = cur_cnt - COUNT_BITS'(1);
                    wr      = 1'b1;
                    mark    = (cur_cnt == COUNT_BITS'(1));
                    res_cnt = new_cnt;
                end
            end
            OP_EXHAUST:
            begin
                st = ST_EXHAUSTED;
            end
            default:
            begin
                st = ST_RANGE;
            end
        endcase
    end

    assign ram_we    = s1_fire && wr;
    assign ram_waddr = s1_id_reg;
    assign ram_wdata = new_cnt;
    assign rel_set   = s1_fire && mark;
    assign rel_id    = s1_id_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            cnt_vld_reg <= '0;
            bp_vld_reg  <= 1'b0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_vld_reg <= in_accept;
            end
            if (s1_adv)
            begin
                out_vld_reg <= s1_vld_reg;
            end
            if (ram_we)
            begin
                cnt_vld_reg[s1_id_reg] <= 1'b1;
                bp_vld_reg             <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_iss_reg <= iss;
            s1_id_reg  <= iss_id;
        end
        if (ram_we)
        begin
            bp_id_reg  <= s1_id_reg;
            bp_cnt_reg <= new_cnt;
        end
        if (s1_fire)
        begin
            res_id_reg  <= s1_iss_reg.res_id;
            status_reg  <= st;
            use_cnt_reg <= USE_COUNT_W'(res_cnt);
        end
    end

    assign out_valid = out_vld_reg;
    assign result_id = res_id_reg;
    assign status    = status_reg;
    assign use_count = use_cnt_reg;

endmodule

FILE: rtl/refcounted_id_allocator_unit.sv
`timescale 1ns / 1ps
// Path from input transfer to result transfer: s1 reg, then result reg.
// Throughput: one command per cycle while the output is not stalled; the count RAM takes one read and one write
// per cycle, and a one-entry bypass covers back-to-back hits on the same id.
// Reset (async, rst_n low): pipeline empty, recycle marks and fresh counter cleared,
// per-id count valid bits cleared so every count reads as zero. No clearing pass.

module refcounted_id_allocator_unit #(
    parameter int NUM_IDS    = rca_pkg::NUM_IDS_DEF,
    parameter int COUNT_BITS = rca_pkg::COUNT_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [rca_pkg::CMD_W-1:0]          cmd,
    input  logic [rca_pkg::TARGET_W-1:0]       target_id,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [rca_pkg::RESULT_ID_W-1:0]    result_id,
    output logic [rca_pkg::STATUS_W-1:0]       status,
    output logic [rca_pkg::USE_COUNT_W-1:0]    use_count
);

    import rca_pkg::*;

    localparam int ID_W    = $clog2(NUM_IDS);
    localparam int FRESH_W = $clog2(NUM_IDS + 1);

    logic                  in_accept;
    logic                  s1_load;
    issue_t                iss;
    logic [ID_W-1:0]       iss_id;
    logic                  rel_set;
    logic [ID_W-1:0]       rel_id;
    logic                  ram_we;
    logic [ID_W-1:0]       ram_waddr;
    logic [COUNT_BITS-1:0] ram_wdata;
    logic [COUNT_BITS-1:0] rd_cnt;

    assign in_stall  = !s1_load;
    assign in_accept = in_valid && s1_load;

    rca_issue #(
        .NUM_IDS (NUM_IDS),
        .ID_W    (ID_W),
        .FRESH_W (FRESH_W)
    ) u_issue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .cmd       (cmd),
        .target_id (target_id),
        .rel_set   (rel_set),
        .rel_id    (rel_id),
        .iss       (iss),
        .iss_id    (iss_id)
    );

    rca_cnt_ram #(
        .DEPTH (NUM_IDS),
        .WIDTH (COUNT_BITS),
        .AW    (ID_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (in_accept),
        .raddr (iss_id),
        .rdata (rd_cnt)
    );

    rca_exec #(
        .NUM_IDS    (NUM_IDS),
        .COUNT_BITS (COUNT_BITS),
        .ID_W       (ID_W)
    ) u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .iss       (iss),
        .iss_id    (iss_id),
        .rd_cnt    (rd_cnt),
        .s1_load   (s1_load),
        .rel_set   (rel_set),
        .rel_id    (rel_id),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result_id (result_id),
        .status    (status),
        .use_count (use_count)
    );

    // Exhausted, out-of-range and unused-release commands never report a count
    a_fail_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_EXHAUSTED || status == ST_RANGE || status == ST_UNUSED)
        |-> use_count == '0)
        else $error("failed command reported a nonzero count");

    // An id is put back on the recycle list only when its count lands on zero or a release finds it at zero
    a_recycle_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rel_set && ram_we |-> ram_wdata == '0)
        else $error("id recycled with nonzero count");

    // A count update always moves its result into the output register
    a_write_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> out_valid)
        else $error("count written without a result");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import rca_pkg::*;

    localparam int N_IDS = NUM_IDS_DEF;
    localparam logic [USE_COUNT_W-1:0] COUNT_MAX = '1;
    // cmd encoding the block does not know; answered as out of range
    localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [RESULT_ID_W-1:0] id;
        status_t                st;
        logic [USE_COUNT_W-1:0] cnt;
    } id_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [CMD_W-1:0]       cmd = '0;
    logic [TARGET_W-1:0]    target_id = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [RESULT_ID_W-1:0] result_id;
    logic [STATUS_W-1:0]    status;
    logic [USE_COUNT_W-1:0] use_count;

    // allocator state as predicted
    logic [8:0]             next_fresh = '0;
    logic                   recycled [N_IDS];
    logic [USE_COUNT_W-1:0] use_cnt [N_IDS];
    int                     n_recycled = 0;

    id_result_t             pending_q [$];
    int                     errors = 0;
    int                     tx_pct = 0;
    int                     rx_pct = 0;
    int                     hold_len = 0;
    logic                   hold_tog = 1'b0;
    logic                   hold_seen = 1'b0;
    int                     hold_cnt = 0;

    refcounted_id_allocator_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .target_id (target_id),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result_id (result_id),
        .status    (status),
        .use_count (use_count)
    );

    always #5 clk = ~clk;

    function automatic status_t raise_count(input int id);
        if (use_cnt[id] == COUNT_MAX)
            return ST_SATURATED;
        use_cnt[id] = use_cnt[id] + 1'b1;
        return ST_OK;
    endfunction

    function automatic id_result_t predict_result(input logic [CMD_W-1:0] c,
                                                  input logic [TARGET_W-1:0] t);
        id_result_t r;
        int id;
        r.id  = t;
        r.st  = ST_RANGE;
        r.cnt = '0;
        id    = t;
        if (c == CMD_ALLOC) begin
            id = -1;
            for (int i = 0; i < N_IDS; i++)
                if (id < 0 && recycled[i])
                    id = i;
            if (id >= 0) begin
                recycled[id] = 1'b0;
                n_recycled--;
            end
            else if (next_fresh < N_IDS) begin
                id = next_fresh;
                next_fresh = next_fresh + 1'b1;
            end
            else begin
                r.id = '0;
                r.st = ST_EXHAUSTED;
                return r;
            end
            r.st  = raise_count(id);
            r.id  = RESULT_ID_W'(id);
            r.cnt = use_cnt[id];
        end
        else if (c == CMD_RETAIN && t < N_IDS) begin
            r.st  = raise_count(id);
            r.cnt = use_cnt[id];
        end
        else if (c == CMD_RELEASE && t < N_IDS) begin
            if (use_cnt[id] == 0)
                r.st = ST_UNUSED;
            else begin
                use_cnt[id] = use_cnt[id] - 1'b1;
                r.st  = ST_OK;
                r.cnt = use_cnt[id];
            end
            // unused release recycles the id as well
            if (use_cnt[id] == 0 && !recycled[id]) begin
                recycled[id] = 1'b1;
                n_recycled++;
            end
        end
        return r;
    endfunction

    task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [TARGET_W-1:0] t);
        if (tx_pct > 0 && $urandom_range(99) < tx_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        cmd       <= c;
        target_id <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_q.push_back(predict_result(c, t));
    endtask

    task automatic send_random_cmd();
        logic [CMD_W-1:0]    c;
        logic [TARGET_W-1:0] t;
        int                  roll;
        roll = $urandom_range(99);
        if (roll < 35)
            c = CMD_ALLOC;
        else if (roll < 60)
            c = CMD_RETAIN;
        else if (roll < 97)
            c = CMD_RELEASE;
        else
            c = CMD_UNKNOWN;
        // mostly a small pool so ids cycle through alloc/retain/release
        t = ($urandom_range(99) < 65) ? TARGET_W'($urandom_range(15)) : TARGET_W'($urandom);
        send_cmd(c, t);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        tx_pct = 0;
        rx_pct = 0;
        send_cmd(CMD_ALLOC, 8'hFF);
        send_cmd(CMD_ALLOC, 8'h00);
        send_cmd(CMD_ALLOC, 8'hA5);
        send_cmd(CMD_RETAIN, 8'd1);
        send_cmd(CMD_RELEASE, 8'd1);
        send_cmd(CMD_RELEASE, 8'd1);
        send_cmd(CMD_RELEASE, 8'd1);
        send_cmd(CMD_ALLOC, 8'h00);
        send_cmd(CMD_RELEASE, 8'd0);
        send_cmd(CMD_RELEASE, 8'd2);
        send_cmd(CMD_ALLOC, 8'h00);
        send_cmd(CMD_ALLOC, 8'h00);
        send_cmd(CMD_RETAIN, 8'd255);
        send_cmd(CMD_RELEASE, 8'd255);
        send_cmd(CMD_RETAIN, 8'd255);
        send_cmd(CMD_ALLOC, 8'h00);
        send_cmd(CMD_UNKNOWN, 8'hAA);
        send_cmd(CMD_UNKNOWN, 8'h55);
        send_cmd(CMD_RELEASE, 8'd200);
        send_cmd(CMD_ALLOC, 8'h00);
        send_cmd(CMD_RELEASE, 8'd0);
        send_cmd(CMD_ALLOC, 8'h00);
    endtask

    task automatic test_random_traffic(input int n, input int tx, input int rx);
        tx_pct = tx;
        rx_pct = rx;
        repeat (n)
            send_random_cmd();
    endtask

    task automatic test_exhaustion();
        tx_pct = 45;
        rx_pct = 0;
        while (next_fresh < N_IDS || n_recycled != 0)
            send_cmd(CMD_ALLOC, TARGET_W'($urandom));
        repeat (3)
            send_cmd(CMD_ALLOC, TARGET_W'($urandom));
    endtask

    task automatic test_backpressure();
        tx_pct   = 0;
        rx_pct   = 0;
        hold_len = 300;
        hold_tog <= ~hold_tog;
        repeat (40)
            send_random_cmd();
        wait_drained();
        repeat (20)
            send_random_cmd();
        wait_drained();
    endtask

    // receiver: long hold on request, else random stall
    always @(posedge clk) begin
        if (hold_tog != hold_seen) begin
            hold_seen <= hold_tog;
            hold_cnt = hold_len;
        end
        if (hold_cnt > 0) begin
            out_stall <= 1'b1;
            hold_cnt--;
        end
        else
            out_stall <= ($urandom_range(99) < rx_pct);
    end

    always @(posedge clk) begin : result_check
        id_result_t e;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected transfer, expected none, got id %0d status %0d count %0d",
                         $time, result_id, status, use_count);
            end
            else begin
                e = pending_q.pop_front();
                if (result_id !== e.id) begin
                    errors++;
                    $display("%0t: result_id expected %0d got %0d", $time, e.id, result_id);
                end
                if (status !== e.st) begin
                    errors++;
                    $display("%0t: status expected %0d got %0d", $time, e.st, status);
                end
                if (use_count !== e.cnt) begin
                    errors++;
                    $display("%0t: use_count expected %0d got %0d", $time, e.cnt, use_count);
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < N_IDS; i++) begin
            recycled[i] = 1'b0;
            use_cnt[i]  = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_traffic(300, 0, 0);
        test_random_traffic(300, 45, 0);
        test_exhaustion();
        test_random_traffic(300, 0, 45);
        test_random_traffic(300, 10, 10);
        test_backpressure();
        wait_drained();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("refcounted_id_allocator_unit: match");
        else
            $display("refcounted_id_allocator_unit: mismatch");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("refcounted_id_allocator_unit: mismatch");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/rca_pkg.sv
rtl/rca_cnt_ram.sv
rtl/rca_issue.sv
rtl/rca_exec.sv
rtl/refcounted_id_allocator_unit.sv
tb/tb.sv
